// ===== hdl/polynomial_rolling_hash_top_defines.svh =====
// Assertion macros for the checker of the rolling hash block.
`ifndef POLYNOMIAL_ROLLING_HASH_TOP_DEFINES_SVH
`define POLYNOMIAL_ROLLING_HASH_TOP_DEFINES_SVH

// Checked only while reset is released.
`define PRH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PRH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/prh_pkg.sv =====
// Shared constants and types of the polynomial rolling hash block.
package prh_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 64;
  localparam int unsigned HASH_W         = 64;
  localparam int unsigned TBL_W          = 32;
  localparam int unsigned TBL_DEPTH      = 256;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned SIZE_W         = 7;
  localparam int unsigned SIZE_RST       = 64;
  localparam int unsigned CFG_W          = 64;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned IN_DATA_W      = BYTE_W + TBL_W;

  localparam logic [HASH_W-1:0] HASH_MULT = HASH_W'(33);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE  = 1'b0,
    CFG_WINDOW_POWER = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    CMD_ROLL = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

endpackage

// ===== hdl/prh_ram.sv =====
// Generic single-write, single-read RAM with a registered, read-first read port.
module prh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/polynomial_rolling_hash_top.sv =====
// Rolling polynomial hash over a sliding byte window, five-stage pipeline.
//
// Takes one transaction per clock while the output side does not stall and returns
// one hash per transaction. A roll transaction stores its byte in the window RAM and
// reads the byte that leaves; the outgoing byte then addresses the substitution
// table, and window_power times that entry is formed as two 32-bit partial products
// in a stage of their own. The hash loop closes in the last stage as hash*33 plus a
// precomputed difference, which is what allows back-to-back transactions. The table
// is held as two copies, one per read address, written together by load transactions;
// every entry a roll touches must be loaded first. Writing window_size restarts the
// hash and the window at once, with no clearing pass. Configuration must be written
// only while no transaction is in flight; the block itself does not enforce this.
module polynomial_rolling_hash_top
  import prh_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // byte_value[7:0], table_word[39:8]
  input  logic [0:0]           in_tuser,   // command[0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [HASH_W-1:0]    out_tdata   // hash_value[63:0]
);

  localparam int unsigned POS_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SIZE_RST_C = (SIZE_RST > MAX_WINDOW) ? MAX_WINDOW : SIZE_RST;
  localparam logic [POS_W-1:0] LAST_RST = POS_W'(SIZE_RST_C - 1);
  localparam logic [POS_W-1:0] LAST_MAX = POS_W'(MAX_WINDOW - 1);
  localparam int unsigned HALF_W     = HASH_W / 2;

  // Input fields
  logic [BYTE_W-1:0] in_byte;
  logic [TBL_W-1:0]  in_word;
  cmd_t              in_cmd;
  logic              in_acc;
  logic              roll_acc;
  logic              load_acc;

  // Window and configuration state
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic [POS_W-1:0]  last_r;
  logic              wrap_r;
  logic [HASH_W-1:0] pow_r;
  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] hash_nxt;
  logic [SIZE_W-1:0] cfg_size;
  logic [POS_W-1:0]  cfg_last;

  // Pipeline control
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic s1_load_r, s2_load_r, s3_load_r, s4_load_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, out_rdy;
  logic adv1, adv2, adv3, adv4;

  // Pipeline payload
  logic [BYTE_W-1:0] old_byte1;
  logic              s1_oldv_r;
  logic [BYTE_W-1:0] old_addr;
  logic [TBL_W-1:0]  tnew1;
  logic [TBL_W-1:0]  tnew2_r;
  logic [TBL_W-1:0]  told2;
  logic [TBL_W-1:0]  tnew3_r;
  logic [HASH_W-1:0] mlo_prod;
  logic [HALF_W-1:0] mhi_prod;
  logic [HASH_W-1:0] mlo3_r;
  logic [HALF_W-1:0] mhi3_r;
  logic [HASH_W-1:0] d4_r;

  assign in_byte = in_tdata[BYTE_W-1:0];
  assign in_word = in_tdata[IN_DATA_W-1:BYTE_W];
  assign in_cmd  = cmd_t'(in_tuser[0]);

  // Each stage moves when the stage after it is empty or moving.
  assign out_rdy = !out_v_r || out_tready;
  assign s4_rdy  = !s4_v_r || out_rdy;
  assign s3_rdy  = !s3_v_r || s4_rdy;
  assign s2_rdy  = !s2_v_r || s3_rdy;
  assign s1_rdy  = !s1_v_r || s2_rdy;
  assign adv1    = s1_v_r && s2_rdy;
  assign adv2    = s2_v_r && s3_rdy;
  assign adv3    = s3_v_r && s4_rdy;
  assign adv4    = s4_v_r && out_rdy;

  assign in_tready = rst_n && s1_rdy;
  assign in_acc    = in_tvalid && in_tready;
  assign roll_acc  = in_acc && (in_cmd == CMD_ROLL);
  assign load_acc  = in_acc && (in_cmd == CMD_LOAD);

  assign pos_nxt = (pos_r == last_r) ? '0 : POS_W'(pos_r + 1'b1);

  // Clamp a window size write to the supported range, kept as its last position.
  assign cfg_size = cfg_data[SIZE_W-1:0];
  always_comb begin
    priority if (cfg_size == '0) begin
      cfg_last = '0;
    end else if (32'(cfg_size) > MAX_WINDOW) begin
      cfg_last = LAST_MAX;
    end else begin
      cfg_last = POS_W'(cfg_size - 1'b1);
    end
  end

  prh_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (roll_acc),
    .waddr (pos_nxt),
    .wdata (in_byte),
    .re    (roll_acc),
    .raddr (pos_nxt),
    .rdata (old_byte1)
  );

  prh_ram #(
    .WIDTH (TBL_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_new (
    .clk   (clk),
    .we    (load_acc),
    .waddr (in_byte),
    .wdata (in_word),
    .re    (in_acc),
    .raddr (in_byte),
    .rdata (tnew1)
  );

  // Until the ring has gone round once since a restart, the leaving byte is zero.
  assign old_addr = s1_oldv_r ? old_byte1 : '0;

  prh_ram #(
    .WIDTH (TBL_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_old (
    .clk   (clk),
    .we    (load_acc),
    .waddr (in_byte),
    .wdata (in_word),
    .re    (adv1),
    .raddr (old_addr),
    .rdata (told2)
  );

  // window_power * T[old] mod 2^64 from two 32-bit partial products.
  assign mlo_prod = HASH_W'(pow_r[HALF_W-1:0]) * HASH_W'(told2);
  assign mhi_prod = pow_r[HASH_W-1:HALF_W] * told2;

  assign hash_nxt = (hash_r * HASH_MULT) + d4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      pos_r   <= LAST_RST;
      last_r  <= LAST_RST;
      wrap_r  <= 1'b0;
      pow_r   <= '0;
      hash_r  <= '0;
    end else begin
      s1_v_r  <= in_acc || (s1_v_r && !s2_rdy);
      s2_v_r  <= adv1 || (s2_v_r && !s3_rdy);
      s3_v_r  <= adv2 || (s3_v_r && !s4_rdy);
      s4_v_r  <= adv3 || (s4_v_r && !out_rdy);
      out_v_r <= adv4 || (out_v_r && !out_tready);

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WINDOW_SIZE: begin
            last_r <= cfg_last;
            pos_r  <= cfg_last;
            wrap_r <= 1'b0;
            hash_r <= '0;
          end
          CFG_WINDOW_POWER: begin
            pow_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end else begin
        if (roll_acc) begin
          pos_r <= pos_nxt;
          if (pos_nxt == last_r) begin
            wrap_r <= 1'b1;
          end
        end
        if (adv4 && !s4_load_r) begin
          hash_r <= hash_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_load_r <= (in_cmd == CMD_LOAD);
      s1_oldv_r <= wrap_r;
    end
    if (adv1) begin
      s2_load_r <= s1_load_r;
      tnew2_r   <= tnew1;
    end
    if (adv2) begin
      s3_load_r <= s2_load_r;
      tnew3_r   <= tnew2_r;
      mlo3_r    <= mlo_prod;
      mhi3_r    <= mhi_prod;
    end
    if (adv3) begin
      s4_load_r <= s3_load_r;
      d4_r      <= HASH_W'(tnew3_r) - mlo3_r - {mhi3_r, {HALF_W{1'b0}}};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = hash_r;

endmodule

// ===== hdl/prh_checker.sv =====
// Port-level checker of the rolling hash block and its bind to the top level.
`include "polynomial_rolling_hash_top_defines.svh"

module prh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  logic in_acc;

  assign in_acc = in_tvalid && in_tready;

  // No result survives a reset.
  `PRH_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid, "result valid after reset")

  // A stalled result keeps its value.
  `PRH_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // Input is taken whenever the output side can move.
  `PRH_ASSERT(a_no_false_stall, (!out_tvalid || out_tready) |-> in_tready, "input stalled with free output")

  // With no result shown and no accepted transaction still on its way to the output, none appears.
  `PRH_ASSERT(a_no_phantom, !out_tvalid && !$past(in_acc, 1) && !$past(in_acc, 2) && !$past(in_acc, 3) && !$past(in_acc, 4) |=> !out_tvalid, "result without a transaction")

endmodule

bind polynomial_rolling_hash_top prh_checker u_prh_checker (.*);

// ===== dv/polynomial_rolling_hash_top_tb.sv =====
// Self-checking testbench for the polynomial rolling hash block.
`timescale 1ns / 1ps

module polynomial_rolling_hash_top_tb;
  import prh_pkg::*;

  typedef enum logic [1:0] {
    ROW_ROLL,
    ROW_LOAD,
    ROW_CONFIG
  } row_kind_t;

  // One row of the directed part: an item, or a pair of register writes.
  typedef struct {
    row_kind_t   kind;
    logic [7:0]  byte_val;
    logic [63:0] word_or_size;
    logic [63:0] power;
    bit          known;
    logic [63:0] hash;
  } step_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW_SIZE;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;   // byte_value[7:0], table_word[39:8]
  logic [0:0]           in_tuser = CMD_ROLL;   // command[0]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [HASH_W-1:0]    out_tdata;   // hash_value[63:0]

  // Shadow state of the hash engine.
  logic [63:0] hash_acc;
  logic [7:0]  window_mem [MAX_WINDOW_DEF];
  int          ring_pos;
  int          win_size;
  logic [63:0] win_power;
  logic [31:0] sub_tbl [TBL_DEPTH];
  bit          tbl_loaded [TBL_DEPTH];
  logic [7:0]  loaded_idx [$];

  logic [63:0] hash_expect_q [$];
  int          outstanding = 0;
  int          err_cnt = 0;
  int          snd_sent = 0;
  bit          snd_burst = 1'b0;
  step_row_t   directed_rows [$];

  polynomial_rolling_hash_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  function automatic int clamp_size(logic [63:0] v);
    int s;
    s = int'(v[6:0]);
    if (s < 1) s = 1;
    if (s > MAX_WINDOW_DEF) s = MAX_WINDOW_DEF;
    return s;
  endfunction

  function automatic logic [63:0] pow33(int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd33;
    return p;
  endfunction

  function automatic void restart_window();
    hash_acc = '0;
    foreach (window_mem[i]) window_mem[i] = '0;
    ring_pos = win_size - 1;
  endfunction

  function automatic void set_reg(cfg_idx_t idx, logic [63:0] v);
    case (idx)
      CFG_WINDOW_SIZE: begin
        win_size = clamp_size(v);
        restart_window();
      end
      CFG_WINDOW_POWER: begin
        win_power = v;
      end
      default: begin
      end
    endcase
  endfunction

  // Applies one item to the shadow state and returns the hash it produces.
  function automatic logic [63:0] advance_hash(cmd_t cmd, logic [7:0] b, logic [31:0] w);
    int          nxt;
    logic [7:0]  leaving;
    logic [63:0] drop;
    if (cmd == CMD_LOAD) begin
      sub_tbl[b] = w;
      if (!tbl_loaded[b]) loaded_idx.push_back(b);
      tbl_loaded[b] = 1'b1;
    end else begin
      nxt = ring_pos + 1;
      if (nxt >= win_size || nxt >= MAX_WINDOW_DEF) nxt = 0;
      ring_pos = nxt;
      leaving = window_mem[nxt];
      drop = win_power * {32'd0, sub_tbl[leaving]};
      window_mem[nxt] = b;
      hash_acc = hash_acc * 64'd33 + {32'd0, sub_tbl[b]} - drop;
    end
    return hash_acc;
  endfunction

  function automatic int draw_gap(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Offers one item and records its expected hash once the transaction happens.
  task automatic offer(cmd_t cmd, logic [7:0] b, logic [31:0] w, bit known,
                       logic [63:0] hash);
    int          gap;
    logic [63:0] pred;
    if (snd_sent % 50 == 0) snd_burst = ($urandom_range(0, 2) == 0);
    gap = draw_gap(snd_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w, b};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    pred = advance_hash(cmd, b, w);
    hash_expect_q.push_back(known ? hash : pred);
    outstanding++;
    snd_sent++;
  endtask

  // Waits for the pipeline to empty, then writes both registers.
  task automatic reconfigure(logic [63:0] size_val, logic [63:0] power_val, bit size_first);
    in_tvalid <= 1'b0;
    wait (outstanding == 0);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= size_first ? CFG_WINDOW_SIZE : CFG_WINDOW_POWER;
    cfg_data  <= size_first ? size_val : power_val;
    @(posedge clk);
    cfg_index <= size_first ? CFG_WINDOW_POWER : CFG_WINDOW_SIZE;
    cfg_data  <= size_first ? power_val : size_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (size_first) begin
      set_reg(CFG_WINDOW_SIZE, size_val);
      set_reg(CFG_WINDOW_POWER, power_val);
    end else begin
      set_reg(CFG_WINDOW_POWER, power_val);
      set_reg(CFG_WINDOW_SIZE, size_val);
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (hash_expect_q.size() == 0) begin
        $display("%0t: unexpected hash transaction, expected none, actual %h",
                 $time, out_tdata);
        err_cnt++;
      end else begin
        if (out_tdata !== hash_expect_q[0]) begin
          $display("%0t: hash_value mismatch, expected %h, actual %h",
                   $time, hash_expect_q[0], out_tdata);
          err_cnt++;
        end
        void'(hash_expect_q.pop_front());
        outstanding--;
      end
    end
  end

  // Result receiver: random stalls, plus two long hold-offs to back up the pipeline.
  initial begin
    int  stall;
    int  got;
    bit  rcv_burst;
    got = 0;
    rcv_burst = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (got % 40 == 0) rcv_burst = ($urandom_range(0, 2) == 0);
      stall = draw_gap(rcv_burst);
      if (got == 300 || got == 1100) stall = 250;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got++;
    end
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    cmd_t        cmd;
    logic [7:0]  b;
    logic [31:0] w;
    logic [63:0] size_val;
    logic [63:0] power_val;

    win_size  = SIZE_RST;
    win_power = '0;
    foreach (sub_tbl[i]) begin
      sub_tbl[i] = '0;
      tbl_loaded[i] = 1'b0;
    end
    restart_window();

    // Directed part; runs at the reset settings until the first config row.
    directed_rows.push_back('{ROW_LOAD, 8'd0,   64'h0,         64'h0, 1'b1, 64'h0});
    directed_rows.push_back('{ROW_LOAD, 8'd255, 64'hFFFF_FFFF, 64'h0, 1'b1, 64'h0});
    directed_rows.push_back('{ROW_LOAD, 8'd1,   64'h1,         64'h0, 1'b1, 64'h0});
    directed_rows.push_back('{ROW_LOAD, 8'd128, 64'h8000_0000, 64'h0, 1'b1, 64'h0});
    directed_rows.push_back('{ROW_ROLL, 8'd0,   64'h0, 64'h0, 1'b1, 64'h0});
    directed_rows.push_back('{ROW_ROLL, 8'd1,   64'h0, 64'h0, 1'b1, 64'h1});
    directed_rows.push_back('{ROW_ROLL, 8'd255, 64'h0, 64'h0, 1'b0, 64'h0});
    directed_rows.push_back('{ROW_ROLL, 8'd128, 64'h0, 64'h0, 1'b0, 64'h0});
    directed_rows.push_back('{ROW_LOAD, 8'd1,   64'h1234_5678, 64'h0, 1'b0, 64'h0});
    directed_rows.push_back('{ROW_CONFIG, 8'd0, 64'd1, 64'd33, 1'b0, 64'h0});
    directed_rows.push_back('{ROW_ROLL, 8'd1,   64'h0, 64'h0, 1'b1, 64'h1234_5678});
    directed_rows.push_back('{ROW_ROLL, 8'd255, 64'h0, 64'h0, 1'b0, 64'h0});
    directed_rows.push_back('{ROW_ROLL, 8'd255, 64'h0, 64'h0, 1'b0, 64'h0});
    // A size of zero saturates to one.
    directed_rows.push_back('{ROW_CONFIG, 8'd0, 64'd0, {64{1'b1}}, 1'b0, 64'h0});
    directed_rows.push_back('{ROW_ROLL, 8'd255, 64'h0, 64'h0, 1'b1, 64'hFFFF_FFFF});
    directed_rows.push_back('{ROW_ROLL, 8'd128, 64'h0, 64'h0, 1'b0, 64'h0});
    // A size above the maximum saturates to the maximum.
    directed_rows.push_back('{ROW_CONFIG, 8'd0, 64'd127, pow33(64), 1'b0, 64'h0});
    directed_rows.push_back('{ROW_ROLL, 8'd255, 64'h0, 64'h0, 1'b1, 64'hFFFF_FFFF});
    directed_rows.push_back('{ROW_ROLL, 8'd0,   64'h0, 64'h0, 1'b0, 64'h0});
    directed_rows.push_back('{ROW_CONFIG, 8'd0, 64'd2, pow33(2), 1'b0, 64'h0});
    directed_rows.push_back('{ROW_ROLL, 8'd1,   64'h0, 64'h0, 1'b0, 64'h0});
    directed_rows.push_back('{ROW_ROLL, 8'd255, 64'h0, 64'h0, 1'b0, 64'h0});
    directed_rows.push_back('{ROW_ROLL, 8'd128, 64'h0, 64'h0, 1'b0, 64'h0});
    // Only the low seven bits of the size write count.
    directed_rows.push_back('{ROW_CONFIG, 8'd0, 64'h103, pow33(3), 1'b0, 64'h0});
    directed_rows.push_back('{ROW_ROLL, 8'd1,   64'h0, 64'h0, 1'b0, 64'h0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CONFIG: begin
          reconfigure(directed_rows[i].word_or_size, directed_rows[i].power, 1'b1);
        end
        ROW_LOAD: begin
          offer(CMD_LOAD, directed_rows[i].byte_val, directed_rows[i].word_or_size[31:0],
                directed_rows[i].known, directed_rows[i].hash);
        end
        default: begin
          offer(CMD_ROLL, directed_rows[i].byte_val, 32'd0,
                directed_rows[i].known, directed_rows[i].hash);
        end
      endcase
    end

    // Random phases, each starting with a write of the window settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: size_val = 64'd64;
        1: size_val = 64'd1;
        2: size_val = 64'd33;
        3: size_val = 64'd0;
        4: size_val = 64'd127;
        5: size_val = 64'($urandom_range(1, 64));
        6: size_val = 64'd2;
        default: size_val = {$urandom, $urandom};
      endcase
      case (ph % 4)
        1: power_val = {$urandom, $urandom};
        3: power_val = (ph == 3) ? 64'd0 : {64{1'b1}};
        default: power_val = pow33(clamp_size(size_val));
      endcase
      reconfigure(size_val, power_val, bit'($urandom_range(0, 1)));
      repeat (230) begin
        if ($urandom_range(0, 3) == 0) begin
          cmd = CMD_LOAD;
          b = 8'($urandom_range(0, 255));
          case ($urandom_range(0, 9))
            0: w = 32'd0;
            1: w = 32'hFFFF_FFFF;
            default: w = $urandom;
          endcase
        end else begin
          cmd = CMD_ROLL;
          b = 8'($urandom_range(0, 255));
          // Rolls only touch table entries that have been loaded.
          if (!tbl_loaded[b]) b = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
          w = $urandom;
        end
        offer(cmd, b, w, 1'b0, 64'h0);
      end
    end

    in_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
